FILE: hdl/wildcard_glob_matcher_defines.svh
// Assertion helpers for the glob matcher.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WGM_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WGM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/wgm_pkg.sv
package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 128;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int SYM_W           = 8;
    localparam int COUNT_OUT_W     = 16;

    localparam logic [SYM_W-1:0] SYM_STAR = 8'd42;
    localparam logic [SYM_W-1:0] SYM_ANY  = 8'd63;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_REPORT = 3'b100
    } top_state_t;

    typedef enum logic [1:0] {
        SW_IDLE = 2'b01,
        SW_RUN  = 2'b10
    } sweep_state_t;

    // Launch of one text byte into the sweep engine.
    typedef struct packed {
        logic             start;
        logic             fresh;
        logic [SYM_W-1:0] sym;
    } sweep_ctrl_t;

    // Sweep engine status back to the control logic.
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } sweep_stat_t;

endpackage

FILE: hdl/wgm_ram.sv
module wgm_ram import wgm_pkg::*; #(
    parameter int WIDTH = SYM_W,
    parameter int DEPTH = MAX_PATTERN_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/wgm_sweep.sv
module wgm_sweep import wgm_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rstn,
    input  sweep_ctrl_t                          ctrl,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]     len,
    output logic [$clog2(MAX_PATTERN)-1:0]       pat_raddr,
    input  logic [SYM_W-1:0]                     pat_rdata,
    output sweep_stat_t                          stat
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int AW    = $clog2(MAX_PATTERN);

    sweep_state_t     state_reg;
    logic [LEN_W-1:0] pos_reg;
    logic [SYM_W-1:0] sym_reg;
    logic             fresh_reg;
    logic             prev_acl_reg;
    logic             prev_star_reg;
    logic             prev_match_reg;
    logic             prev_ncl_reg;

    logic [LEN_W-1:0] rd_addr;
    logic             act_rdata;
    logic             at_end;
    logic             running;
    logic             in_pat;
    logic             is_star;
    logic             is_match;
    logic             a_raw;
    logic             a_cl;
    logic             n_cl;

    assign running = (state_reg == SW_RUN);
    assign at_end  = (pos_reg == len);

    // Read one position ahead of the one being written back.
    assign rd_addr   = (running && !at_end) ? pos_reg + LEN_W'(1) : '0;
    assign pat_raddr = rd_addr[AW-1:0];

    wgm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PATTERN + 1)
    ) u_act_ram (
        .clk   (clk),
        .we    (running),
        .waddr (pos_reg),
        .wdata (n_cl),
        .raddr (rd_addr),
        .rdata (act_rdata)
    );

    // Star closure of the old set and of the new set both ripple upward,
    // so carry them one position at a time.
    always_comb begin
        in_pat   = !at_end;
        is_star  = in_pat && (pat_rdata == SYM_STAR);
        is_match = in_pat && ((pat_rdata == SYM_ANY) || (pat_rdata == sym_reg));
        a_raw    = fresh_reg ? (pos_reg == '0) : act_rdata;
        a_cl     = a_raw | (prev_acl_reg & prev_star_reg);
        n_cl     = (a_cl & is_star)
                 | (prev_acl_reg & !prev_star_reg & prev_match_reg)
                 | (prev_ncl_reg & prev_star_reg);
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= SW_IDLE;
        end else begin
            case (state_reg)
                SW_IDLE: begin
                    if (ctrl.start) begin
                        state_reg <= SW_RUN;
                    end
                end
                SW_RUN: begin
                    if (at_end) begin
                        state_reg <= SW_IDLE;
                    end
                end
                default: begin
                    state_reg <= SW_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (!running && ctrl.start) begin
            pos_reg        <= '0;
            sym_reg        <= ctrl.sym;
            fresh_reg      <= ctrl.fresh;
            prev_acl_reg   <= 1'b0;
            prev_star_reg  <= 1'b0;
            prev_match_reg <= 1'b0;
            prev_ncl_reg   <= 1'b0;
        end else if (running) begin
            pos_reg        <= pos_reg + LEN_W'(1);
            prev_acl_reg   <= a_cl;
            prev_star_reg  <= is_star;
            prev_match_reg <= is_match;
            prev_ncl_reg   <= n_cl;
        end
    end

    assign stat.busy = running;
    assign stat.done = running && at_end;
    assign stat.hit  = n_cl;

endmodule

FILE: hdl/wildcard_glob_matcher.sv
// Glob line matcher. Load a pattern first as requests with s_kind = 0 ('*' matches any
// run of bytes, '?' any single byte, runs of stars fold into one, bytes beyond
// MAX_PATTERN drop, s_last ends the pattern and the next pattern request starts a new
// pattern and clears the match count). Then stream text requests with s_kind = 1; the
// last byte of each line yields one result with m_matched and the saturating count of
// matched lines. For a text request, with L the stored pattern length, the sweep
// engine walks positions 0..L, one per cycle, through the pattern memory and the
// active-position memory (both with a registered read, written back one position
// behind the read). The last byte of a line then passes a report state to hand off
// the result; a new request is taken while an earlier result still waits on m_ready.
// There is no clearing pass after reset: a flag marks a line start, where the active
// set reads as position zero only.
`include "wildcard_glob_matcher_defines.svh"

module wildcard_glob_matcher import wgm_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_kind,
    input  logic [SYM_W-1:0]       s_symbol,
    input  logic                   s_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_matched,
    output logic [COUNT_OUT_W-1:0] m_match_count
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int AW    = $clog2(MAX_PATTERN);

    top_state_t            state_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  pat_done_reg;
    logic                  last_star_reg;
    logic                  line_started_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  last_reg;
    logic                  hit_reg;
    logic                  m_valid_reg;
    logic                  m_matched_reg;
    logic [COUNT_OUT_W-1:0] m_count_reg;

    logic                  accept;
    logic                  pat_req;
    logic                  new_pat;
    logic [LEN_W-1:0]      cur_len;
    logic                  merge;
    logic                  store;
    logic                  out_free;
    logic [COUNT_BITS+COUNT_OUT_W-1:0] count_ext;

    sweep_ctrl_t           sweep_ctrl;
    sweep_stat_t           sweep_stat;
    logic [AW-1:0]         pat_raddr;
    logic [SYM_W-1:0]      pat_rdata;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign pat_req  = accept && !s_kind;
    assign out_free = !m_valid_reg || m_ready;

    // Pattern load: restart after a finished pattern, fold repeated stars, drop overflow.
    always_comb begin
        new_pat = pat_done_reg || (len_reg == '0);
        cur_len = new_pat ? '0 : len_reg;
        merge   = (s_symbol == SYM_STAR) && (cur_len != '0) && last_star_reg;
        store   = (cur_len < LEN_W'(MAX_PATTERN)) && !merge;
    end

    wgm_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PATTERN)
    ) u_pat_ram (
        .clk   (aclk),
        .we    (pat_req && store),
        .waddr (cur_len[AW-1:0]),
        .wdata (s_symbol),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    // Launch a sweep on every text request; a line start sees position zero only.
    assign sweep_ctrl.start = accept && s_kind;
    assign sweep_ctrl.fresh = !line_started_reg;
    assign sweep_ctrl.sym   = s_symbol;

    wgm_sweep #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_sweep (
        .clk       (aclk),
        .rstn      (aresetn),
        .ctrl      (sweep_ctrl),
        .len       (len_reg),
        .pat_raddr (pat_raddr),
        .pat_rdata (pat_rdata),
        .stat      (sweep_stat)
    );

    // Zero-extend or truncate the count to the output field.
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            len_reg          <= '0;
            pat_done_reg     <= 1'b0;
            last_star_reg    <= 1'b0;
            line_started_reg <= 1'b0;
            count_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            // Raise the result on hand-off, drop it once taken.
            if ((state_reg == ST_REPORT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pat_req) begin
                        if (store) begin
                            len_reg       <= cur_len + LEN_W'(1);
                            last_star_reg <= (s_symbol == SYM_STAR);
                        end else begin
                            len_reg <= cur_len;
                        end
                        if (new_pat) begin
                            count_reg <= '0;
                        end
                        pat_done_reg     <= s_last;
                        line_started_reg <= 1'b0;
                    end else if (accept) begin
                        state_reg <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (sweep_stat.done) begin
                        if (last_reg) begin
                            // Advance the count on a hit, hold at all ones.
                            if (sweep_stat.hit && (count_reg != '1)) begin
                                count_reg <= count_reg + COUNT_BITS'(1);
                            end
                            state_reg <= ST_REPORT;
                        end else begin
                            line_started_reg <= 1'b1;
                            state_reg        <= ST_IDLE;
                        end
                    end
                end
                ST_REPORT: begin
                    if (out_free) begin
                        line_started_reg <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Request and result payload, no reset.
    always_ff @(posedge aclk) begin
        if (accept && s_kind) begin
            last_reg <= s_last;
        end
        if ((state_reg == ST_SWEEP) && sweep_stat.done) begin
            hit_reg <= sweep_stat.hit;
        end
        if ((state_reg == ST_REPORT) && out_free) begin
            m_matched_reg <= hit_reg;
            m_count_reg   <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_matched     = m_matched_reg;
    assign m_match_count = m_count_reg;

    `WGM_ASSERT_IMPLY(a_idle_no_sweep, aclk, aresetn, state_reg == ST_IDLE, !sweep_stat.busy, "sweep running while control idle")
    `WGM_ASSERT_IMPLY(a_done_in_sweep, aclk, aresetn, sweep_stat.done, state_reg == ST_SWEEP, "sweep finished outside sweep state")
    `WGM_ASSERT_IMPLY(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LEN_W'(MAX_PATTERN), "pattern length beyond store depth")
    `WGM_ASSERT_NEXT(a_text_starts_sweep, aclk, aresetn, accept && s_kind, sweep_stat.busy, "text request did not start a sweep")

endmodule
